FILE: hdl/uoi_pkg.sv
// Package for the unicycle odometry integrator.
// Holds fixed-point constants, register indexes and the CORDIC arctangent table.
// No dependencies.
`default_nettype none

package uoi_pkg;

  // Default number of CORDIC micro-rotations (range 8 to 32)
  localparam int CORDIC_ITERATIONS_DEF = 16;
  // Table length; iteration counts above it stop here
  localparam int ATAN_DEPTH = 32;

  // 8/pi scaled by 2^30: Q3.28 radians to 32-bit binary angle
  localparam logic [31:0] ANGLE_SCALE = 32'd2734261102;
  // Inverse CORDIC gain in Q2.30
  localparam logic [32:0] CORDIC_GAIN_INV = 33'd652032874;

  localparam logic [15:0] STEP_TIME_RESET = 16'd66;

  // Register index (paddr word bit)
  localparam logic REG_STEP_TIME = 1'b0;

  // atan(2^-i) as a 32-bit binary angle, rounded
  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      5'd31: v = 32'h00000000;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/unicycle_odometry_integrator.sv
// Unicycle dead-reckoning odometry integrator, top level.
// One iterative CORDIC plus one shared 32x32 multiplier under a one-hot sequencer.
// Depends on uoi_pkg.
`default_nettype none

// Each input beat is one tick (forward speed, yaw rate). The block integrates a
// planar pose from the origin: x and y advance by step_time*speed times cos/sin
// of the old heading (Q16.16, saturating), then the 32-bit binary-angle heading
// adds step_time*yaw_rate and wraps. Each tick yields one result beat carrying
// the pose, the top 16 heading bits and speed times cos/sin of the new heading.
// One item occupies the block from acceptance to its result: two full CORDIC
// passes of min(CORDIC_ITERATIONS, 32) micro-rotations, one micro-rotation per
// cycle, and the single multiplier is visited seven times for the distance,
// turn, angle scaling, position and velocity products. in_stall is high from
// the accepting edge until the result moves to the output register; the next
// tick is taken in the idle state that follows. A finished result sits in the
// output register, so the next tick is taken while it waits; only a further
// result stalls there.
// step_time sits at byte address 0 of the APB port, reset value 66; write it
// only while the block is idle.

module unicycle_odometry_integrator #(
  parameter int CORDIC_ITERATIONS = uoi_pkg::CORDIC_ITERATIONS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // APB register port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  // tick input
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] lin_speed,
  input  wire logic signed [15:0] yaw_rate,
  // result output
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      pos_x,
  output logic signed [31:0]      pos_y,
  output logic        [15:0]      heading,
  output logic signed [15:0]      vel_x,
  output logic signed [15:0]      vel_y
);

  localparam int ITERS = (CORDIC_ITERATIONS > uoi_pkg::ATAN_DEPTH) ?
                         uoi_pkg::ATAN_DEPTH : CORDIC_ITERATIONS;
  localparam int IW    = $clog2(ITERS);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_DIS   = 12'b0000_0000_0010,
    ST_TURN  = 12'b0000_0000_0100,
    ST_SCALE = 12'b0000_0000_1000,
    ST_DTURN = 12'b0000_0001_0000,
    ST_ROT   = 12'b0000_0010_0000,
    ST_POSX  = 12'b0000_0100_0000,
    ST_POSY  = 12'b0000_1000_0000,
    ST_HEAD  = 12'b0001_0000_0000,
    ST_VX    = 12'b0010_0000_0000,
    ST_VY    = 12'b0100_0000_0000,
    ST_DONE  = 12'b1000_0000_0000
  } state_t;

  state_t state;

  // configuration
  logic [15:0] step_time;

  // architectural state
  logic signed [31:0] pos_x_acc;
  logic signed [31:0] pos_y_acc;
  logic        [31:0] heading_acc;

  // per-item working registers
  logic signed [15:0] speed_r;
  logic signed [15:0] rate_r;
  logic        [31:0] dis_mag;
  logic        [31:0] dturn;
  logic signed [15:0] vx_r;
  logic        [63:0] prod;
  logic               pass2;

  // CORDIC registers, Q2.30 with headroom
  logic signed [32:0] cx;
  logic signed [32:0] cy;
  logic signed [32:0] cz;
  logic        [1:0]  quad;
  logic      [IW-1:0] iter;

  // ---------------------------------------------------------------------------
  // APB: always ready, one register
  // ---------------------------------------------------------------------------
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == uoi_pkg::REG_STEP_TIME);

  always_comb begin
    if (paddr[2] == uoi_pkg::REG_STEP_TIME) begin
      prdata = {16'd0, step_time};
    end else begin
      prdata = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_time <= uoi_pkg::STEP_TIME_RESET;
    end else if (cfg_wr) begin
      step_time <= pwdata[15:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  logic in_fire;
  logic out_free;
  logic done_fire;

  assign in_stall  = (state != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign done_fire = (state == ST_DONE) && out_free;

  // ---------------------------------------------------------------------------
  // Sign and magnitude views
  // ---------------------------------------------------------------------------
  logic        spd_neg;
  logic [15:0] spd_mag;
  logic        rate_neg;
  logic [15:0] rate_mag;

  assign spd_neg  = speed_r[15];
  assign spd_mag  = spd_neg ? (16'd0 - speed_r) : speed_r;
  assign rate_neg = rate_r[15];
  assign rate_mag = rate_neg ? (16'd0 - rate_r) : rate_r;

  // quadrant unfold of the rotated vector
  logic signed [32:0] c_val;
  logic signed [32:0] s_val;
  logic        [31:0] c_mag;
  logic        [31:0] s_mag;

  always_comb begin
    unique case (quad)
      2'd0: begin c_val = cx;  s_val = cy;  end
      2'd1: begin c_val = -cy; s_val = cx;  end
      2'd2: begin c_val = -cx; s_val = -cy; end
      2'd3: begin c_val = cy;  s_val = -cx; end
      default: begin c_val = cx; s_val = cy; end
    endcase
  end

  logic [32:0] c_abs;
  logic [32:0] s_abs;

  assign c_abs = c_val[32] ? (33'd0 - c_val) : c_val;
  assign s_abs = s_val[32] ? (33'd0 - s_val) : s_val;
  assign c_mag = c_abs[31:0];
  assign s_mag = s_abs[31:0];

  // ---------------------------------------------------------------------------
  // Shared multiplier: operands selected by the sequencer, product registered
  // ---------------------------------------------------------------------------
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;

  always_comb begin
    unique case (state)
      ST_DIS:   begin mul_a = 32'(step_time); mul_b = 32'(spd_mag);  end
      ST_TURN:  begin mul_a = 32'(step_time); mul_b = 32'(rate_mag); end
      ST_SCALE: begin mul_a = prod[31:0];     mul_b = uoi_pkg::ANGLE_SCALE; end
      ST_POSX:  begin mul_a = dis_mag;        mul_b = c_mag; end
      ST_POSY:  begin mul_a = dis_mag;        mul_b = s_mag; end
      ST_VX:    begin mul_a = 32'(spd_mag);   mul_b = c_mag; end
      ST_VY:    begin mul_a = 32'(spd_mag);   mul_b = s_mag; end
      default:  begin mul_a = 32'd0;          mul_b = 32'd0; end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // ---------------------------------------------------------------------------
  // Rounding of the registered product, half away from zero on the magnitude
  // ---------------------------------------------------------------------------
  logic [64:0] sum30;
  logic [64:0] sum38;
  logic [34:0] r30;
  logic [26:0] r38;
  logic        prod_neg;

  assign sum30 = {1'b0, prod} + 65'h0_0000_0000_2000_0000;
  assign sum38 = {1'b0, prod} + 65'h0_0000_0020_0000_0000;
  assign r30   = sum30[64:30];
  assign r38   = sum38[64:38];

  // cosine products are consumed in POSY and VY, sine products in HEAD and DONE
  always_comb begin
    if ((state == ST_POSY) || (state == ST_VY)) begin
      prod_neg = spd_neg ^ c_val[32];
    end else begin
      prod_neg = spd_neg ^ s_val[32];
    end
  end

  // heading increment
  logic [31:0] dturn_next;
  assign dturn_next = rate_neg ? (32'd0 - r30[31:0]) : r30[31:0];

  // position add with saturation
  logic signed [33:0] pos_step;
  logic signed [31:0] pos_src;
  logic signed [33:0] pos_sum;
  logic signed [31:0] pos_sat;

  assign pos_step = prod_neg ? (34'sd0 - $signed({7'd0, r38})) : $signed({7'd0, r38});
  assign pos_src  = (state == ST_POSY) ? pos_x_acc : pos_y_acc;
  assign pos_sum  = 34'(pos_src) + pos_step;

  always_comb begin
    if ((pos_sum[33:31] == 3'b000) || (pos_sum[33:31] == 3'b111)) begin
      pos_sat = pos_sum[31:0];
    end else if (pos_sum[33]) begin
      pos_sat = 32'sh8000_0000;
    end else begin
      pos_sat = 32'sh7FFF_FFFF;
    end
  end

  // velocity with saturation to Q8.8
  logic signed [35:0] vel_full;
  logic signed [15:0] vel_sat;

  assign vel_full = prod_neg ? (36'sd0 - $signed({1'b0, r30})) : $signed({1'b0, r30});

  always_comb begin
    if (vel_full > 36'sd32767) begin
      vel_sat = 16'sh7FFF;
    end else if (vel_full < -36'sd32768) begin
      vel_sat = 16'sh8000;
    end else begin
      vel_sat = vel_full[15:0];
    end
  end

  // ---------------------------------------------------------------------------
  // CORDIC: fold by the nearest quarter turn, then one micro-rotation a cycle
  // ---------------------------------------------------------------------------
  logic [31:0] heading_new;
  logic [31:0] load_ang;
  logic [31:0] ang_bias;
  logic [1:0]  load_quad;
  logic [31:0] load_res;

  assign heading_new = heading_acc + dturn;
  assign load_ang    = (state == ST_DTURN) ? heading_acc : heading_new;
  assign ang_bias    = load_ang + 32'h2000_0000;
  assign load_quad   = ang_bias[31:30];
  assign load_res    = load_ang - {load_quad, 30'd0};

  logic signed [32:0] x_sh;
  logic signed [32:0] y_sh;
  logic signed [32:0] at_ext;
  logic signed [32:0] cx_next;
  logic signed [32:0] cy_next;
  logic signed [32:0] cz_next;
  logic               last_iter;

  assign x_sh      = cx >>> iter;
  assign y_sh      = cy >>> iter;
  assign at_ext    = $signed({1'b0, uoi_pkg::atan_entry(5'(iter))});
  assign last_iter = (iter == IW'(ITERS - 1));

  always_comb begin
    if (!cz[32]) begin
      cx_next = cx - y_sh;
      cy_next = cy + x_sh;
      cz_next = cz - at_ext;
    end else begin
      cx_next = cx + y_sh;
      cy_next = cy - x_sh;
      cz_next = cz + at_ext;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer and datapath registers
  // ---------------------------------------------------------------------------
  logic cordic_load;
  assign cordic_load = (state == ST_DTURN) || (state == ST_HEAD);

  always_ff @(posedge clk) begin
    if (cordic_load) begin
      cx   <= $signed(uoi_pkg::CORDIC_GAIN_INV);
      cy   <= 33'sd0;
      cz   <= $signed({load_res[31], load_res});
      quad <= load_quad;
      iter <= '0;
    end else if (state == ST_ROT) begin
      cx   <= cx_next;
      cy   <= cy_next;
      cz   <= cz_next;
      iter <= iter + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      pos_x_acc   <= '0;
      pos_y_acc   <= '0;
      heading_acc <= '0;
      pass2       <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            state <= ST_DIS;
          end
        end
        ST_DIS: begin
          state <= ST_TURN;
        end
        ST_TURN: begin
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          state <= ST_DTURN;
        end
        ST_DTURN: begin
          pass2 <= 1'b0;
          state <= ST_ROT;
        end
        ST_ROT: begin
          if (last_iter) begin
            state <= pass2 ? ST_VX : ST_POSX;
          end
        end
        ST_POSX: begin
          state <= ST_POSY;
        end
        ST_POSY: begin
          pos_x_acc <= pos_sat;
          state     <= ST_HEAD;
        end
        ST_HEAD: begin
          pos_y_acc   <= pos_sat;
          heading_acc <= heading_new;
          pass2       <= 1'b1;
          state       <= ST_ROT;
        end
        ST_VX: begin
          state <= ST_VY;
        end
        ST_VY: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload side: latch the tick, products and intermediate results
  always_ff @(posedge clk) begin
    if (in_fire) begin
      speed_r <= lin_speed;
      rate_r  <= yaw_rate;
    end
    if (state == ST_TURN) begin
      dis_mag <= prod[31:0];
    end
    if (state == ST_DTURN) begin
      dturn <= dturn_next;
    end
    if (state == ST_VY) begin
      vx_r <= vel_sat;
    end
    // hold the product in every state that does not feed the multiplier
    if ((state == ST_DIS) || (state == ST_TURN) || (state == ST_SCALE) ||
        (state == ST_POSX) || (state == ST_POSY) || (state == ST_VX) ||
        (state == ST_VY)) begin
      prod <= mul_p;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      pos_x   <= pos_x_acc;
      pos_y   <= pos_y_acc;
      heading <= heading_acc[31:16];
      vel_x   <= vx_r;
      vel_y   <= vel_sat;
    end
  end

endmodule

`default_nettype wire
